// ===== src/mbo_pkg.sv =====
// Shared types, codes and constants for the market-by-order book core.
package mbo_pkg;

  localparam int ORDER_SLOTS_DEF = 4096;
  localparam int LEVELS_DEF      = 64;

  localparam int PRICE_W = 64;
  localparam int SUM_W   = 64;
  localparam int CNT_W   = 13;
  localparam int QTY_W   = 32;
  localparam int KEY_W   = 64;
  localparam int INST_W  = 32;

  localparam logic [2:0] CMD_ADD    = 3'd0;
  localparam logic [2:0] CMD_CANCEL = 3'd1;
  localparam logic [2:0] CMD_MODIFY = 3'd2;
  localparam logic [2:0] CMD_TRADE  = 3'd3;
  localparam logic [2:0] CMD_FILL   = 3'd4;
  localparam logic [2:0] CMD_CLEAR  = 3'd5;

  localparam logic [1:0] ST_APPLIED = 2'd0;
  localparam logic [1:0] ST_IGNORED = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  localparam logic signed [PRICE_W-1:0] UNDEF_PRICE = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic [SUM_W-1:0]          SUM_MAX     = '1;
  localparam logic [CNT_W-1:0]          CNT_MAX     = '1;

  typedef enum logic [1:0] {SM_FIND, SM_CLR_SIDE, SM_CLR_ALL} slot_mode_t;
  typedef enum logic [1:0] {SO_NONE, SO_FREE, SO_PUT_NEW, SO_CANCEL} slot_op_t;
  typedef enum logic {LM_FIND, LM_BEST} lv_mode_t;
  typedef enum logic [2:0] {
    LO_NONE, LO_REDUCE_ALL, LO_REDUCE_CUT, LO_GROW, LO_PLACE, LO_CLR_SIDE, LO_CLR_ALL
  } lv_op_t;

  typedef struct packed {
    logic       load_item;
    logic       load_out;
    logic       set_full;
    logic       slot_start;
    slot_mode_t slot_mode;
    slot_op_t   slot_op;
    logic       lv_start;
    lv_mode_t   lv_mode;
    logic       lv_old;
    lv_op_t     lv_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       slot_done;
    logic       lv_done;
    logic       inst_match;
    logic [2:0] cmd;
    logic       side_ok;
    logic       tob;
    logic       qty_zero;
    logic       undef;
    logic       sfound;
    logic       sempty_ok;
    logic       lfound;
    logic       lempty_ok;
    logic       out_free;
  } ctrl_sts_t;

endpackage

// ===== src/mbo_dp.sv =====
// Datapath: order table, price level table, scan units and result register.
module mbo_dp import mbo_pkg::*; #(
  parameter int ORDER_SLOTS     = ORDER_SLOTS_DEF,
  parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [2:0]                i_cmd,
  input  logic [INST_W-1:0]         i_inst,
  input  logic [1:0]                i_side,
  input  logic signed [PRICE_W-1:0] i_price,
  input  logic [QTY_W-1:0]          i_qty,
  input  logic [KEY_W-1:0]          i_key,
  input  logic                      i_tob,
  input  logic                      cfg_we,
  input  logic [INST_W-1:0]         cfg_wdata,
  input  ctrl_cmd_t                 cmd,
  output ctrl_sts_t                 sts,
  input  logic                      out_tready,
  output logic                      out_valid,
  output logic [1:0]                o_status,
  output logic                      o_bid_valid,
  output logic signed [PRICE_W-1:0] o_bid_price,
  output logic [SUM_W-1:0]          o_bid_total,
  output logic [CNT_W-1:0]          o_bid_orders,
  output logic                      o_ask_valid,
  output logic signed [PRICE_W-1:0] o_ask_price,
  output logic [SUM_W-1:0]          o_ask_total,
  output logic [CNT_W-1:0]          o_ask_orders,
  output logic [63:0]               o_event_total
);

  localparam int SW  = $clog2(ORDER_SLOTS);
  localparam int NLV = 2 * LEVELS_PER_SIDE;
  localparam int LW  = $clog2(NLV);
  localparam logic [SW:0] SLOT_END = (SW+1)'(ORDER_SLOTS);
  localparam logic [LW:0] LV_HALF  = (LW+1)'(LEVELS_PER_SIDE);
  localparam logic [LW:0] LV_ALL   = (LW+1)'(NLV);

  // item and book registers
  logic [2:0]                cmd_r;
  logic [1:0]                side_r;
  logic signed [PRICE_W-1:0] price_r;
  logic [QTY_W-1:0]          qty_r;
  logic [KEY_W-1:0]          key_r;
  logic                      tob_r;
  logic                      inst_ok_r;
  logic [INST_W-1:0]         filter_r;
  logic [63:0]               evt_r;
  logic [1:0]                status_r;

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      cmd_r   <= i_cmd;
      side_r  <= i_side;
      price_r <= i_price;
      qty_r   <= i_qty;
      key_r   <= i_key;
      tob_r   <= i_tob;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_r  <= '0;
      evt_r     <= '0;
      status_r  <= ST_APPLIED;
      inst_ok_r <= 1'b0;
    end else begin
      if (cfg_we) filter_r <= cfg_wdata;
      if (cmd.load_item) begin
        inst_ok_r <= (i_inst == filter_r);
        status_r  <= (i_inst == filter_r) ? ST_APPLIED : ST_IGNORED;
        if (i_inst == filter_r && i_cmd <= CMD_CLEAR) evt_r <= evt_r + 64'd1;
      end else if (cmd.set_full) begin
        status_r <= ST_FULL;
      end
    end
  end

  // order table
  logic [KEY_W-1:0]          sm_key   [ORDER_SLOTS];
  logic signed [PRICE_W-1:0] sm_price [ORDER_SLOTS];
  logic [QTY_W-1:0]          sm_size  [ORDER_SLOTS];
  logic                      sm_side  [ORDER_SLOTS];
  logic                      sm_used  [ORDER_SLOTS];

  logic                      s_act_r, s_rv_r;
  logic [SW:0]               sp_r;
  logic [SW-1:0]             s_ra_r;
  slot_mode_t                s_mode_r;
  logic [KEY_W-1:0]          rd_key;
  logic signed [PRICE_W-1:0] rd_price;
  logic [QTY_W-1:0]          rd_size;
  logic                      rd_side, rd_used;
  logic                      slot_done;

  logic                      sfound_r, sempty_ok_r;
  logic [SW-1:0]             sidx_r, sempty_r;
  logic signed [PRICE_W-1:0] s_price_r;
  logic [QTY_W-1:0]          s_size_r;
  logic                      s_side_r;

  assign slot_done = s_act_r && (sp_r == SLOT_END) && !s_rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_act_r  <= 1'b0;
      s_rv_r   <= 1'b0;
      sp_r     <= '0;
      s_mode_r <= SM_FIND;
    end else begin
      s_rv_r <= s_act_r && !cmd.slot_start && (sp_r != SLOT_END) && (s_mode_r != SM_CLR_ALL);
      if (cmd.slot_start) begin
        s_act_r  <= 1'b1;
        sp_r     <= '0;
        s_mode_r <= cmd.slot_mode;
      end else if (s_act_r) begin
        if (sp_r != SLOT_END) sp_r <= sp_r + 1'b1;
        else if (!s_rv_r) s_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    s_ra_r   <= sp_r[SW-1:0];
    rd_key   <= sm_key[sp_r[SW-1:0]];
    rd_price <= sm_price[sp_r[SW-1:0]];
    rd_size  <= sm_size[sp_r[SW-1:0]];
    rd_side  <= sm_side[sp_r[SW-1:0]];
    rd_used  <= sm_used[sp_r[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.slot_start) begin
      sfound_r    <= 1'b0;
      sempty_ok_r <= 1'b0;
    end else if (s_rv_r && s_mode_r == SM_FIND) begin
      if (rd_used && rd_key == key_r && !sfound_r) begin
        sfound_r  <= 1'b1;
        sidx_r    <= s_ra_r;
        s_price_r <= rd_price;
        s_size_r  <= rd_size;
        s_side_r  <= rd_side;
      end
      if (!rd_used && !sempty_ok_r) begin
        sempty_ok_r <= 1'b1;
        sempty_r    <= s_ra_r;
      end
    end
  end

  logic [QTY_W-1:0] cut, left;
  logic             left_zero;
  assign cut       = (qty_r > s_size_r) ? s_size_r : qty_r;
  assign left      = s_size_r - cut;
  assign left_zero = (left == '0);

  logic                      sw_used_en, sw_data_en, sw_used_val;
  logic [SW-1:0]             sw_addr;
  logic signed [PRICE_W-1:0] sw_price;
  logic [QTY_W-1:0]          sw_size;
  logic                      sw_side;

  always_comb begin
    sw_used_en  = 1'b0;
    sw_data_en  = 1'b0;
    sw_used_val = 1'b0;
    sw_addr     = sfound_r ? sidx_r : sempty_r;
    sw_price    = price_r;
    sw_size     = qty_r;
    sw_side     = side_r[0];
    if (s_act_r && s_mode_r == SM_CLR_ALL && sp_r != SLOT_END) begin
      sw_used_en = 1'b1;
      sw_addr    = sp_r[SW-1:0];
    end else if (s_rv_r && s_mode_r == SM_CLR_SIDE && rd_used && rd_side == side_r[0]) begin
      sw_used_en = 1'b1;
      sw_addr    = s_ra_r;
    end else begin
      case (cmd.slot_op)
        SO_FREE: sw_used_en = 1'b1;
        SO_PUT_NEW: begin
          sw_used_en  = 1'b1;
          sw_used_val = 1'b1;
          sw_data_en  = 1'b1;
        end
        SO_CANCEL: begin
          if (left_zero) begin
            sw_used_en = 1'b1;
          end else begin
            sw_data_en = 1'b1;
            sw_size    = left;
            sw_price   = s_price_r;
            sw_side    = s_side_r;
          end
        end
        default: sw_used_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sw_used_en) sm_used[sw_addr] <= sw_used_val;
    if (sw_data_en) begin
      sm_key[sw_addr]   <= key_r;
      sm_price[sw_addr] <= sw_price;
      sm_size[sw_addr]  <= sw_size;
      sm_side[sw_addr]  <= sw_side;
    end
  end

  // price level table
  logic [NLV-1:0]            lu_r;
  logic signed [PRICE_W-1:0] lm_price [NLV];
  logic [SUM_W-1:0]          lm_sum   [NLV];
  logic [CNT_W-1:0]          lm_cnt   [NLV];

  logic                      l_act_r, l_rv_r, l_ru_r;
  logic [LW:0]               lp_r, l_base_r, l_lim, l_addr_full;
  logic [LW-1:0]             l_addr, l_ra_r;
  lv_mode_t                  l_mode_r;
  logic signed [PRICE_W-1:0] lt_price_r, lr_price;
  logic [SUM_W-1:0]          lr_sum;
  logic [CNT_W-1:0]          lr_cnt;
  logic                      lv_done;

  assign l_lim       = (l_mode_r == LM_BEST) ? LV_ALL : LV_HALF;
  assign l_addr_full = l_base_r + lp_r;
  assign l_addr      = l_addr_full[LW-1:0];
  assign lv_done     = l_act_r && (lp_r == l_lim) && !l_rv_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l_act_r  <= 1'b0;
      l_rv_r   <= 1'b0;
      lp_r     <= '0;
      l_base_r <= '0;
      l_mode_r <= LM_FIND;
    end else begin
      l_rv_r <= l_act_r && !cmd.lv_start && (lp_r != l_lim);
      if (cmd.lv_start) begin
        l_act_r  <= 1'b1;
        lp_r     <= '0;
        l_mode_r <= cmd.lv_mode;
        if (cmd.lv_mode == LM_BEST) l_base_r <= '0;
        else l_base_r <= (cmd.lv_old ? s_side_r : side_r[0]) ? LV_HALF : '0;
      end else if (l_act_r) begin
        if (lp_r != l_lim) lp_r <= lp_r + 1'b1;
        else if (!l_rv_r) l_act_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lv_start) lt_price_r <= cmd.lv_old ? s_price_r : price_r;
    l_ra_r   <= l_addr;
    l_ru_r   <= lu_r[l_addr];
    lr_price <= lm_price[l_addr];
    lr_sum   <= lm_sum[l_addr];
    lr_cnt   <= lm_cnt[l_addr];
  end

  logic                      lfound_r, lempty_ok_r;
  logic [LW-1:0]             lidx_r, lempty_r;
  logic signed [PRICE_W-1:0] lprice_r;
  logic [SUM_W-1:0]          lsum_r;
  logic [CNT_W-1:0]          lcnt_r;
  logic                      bid_v_r, ask_v_r;
  logic signed [PRICE_W-1:0] bid_p_r, ask_p_r;
  logic [SUM_W-1:0]          bid_s_r, ask_s_r;
  logic [CNT_W-1:0]          bid_c_r, ask_c_r;

  always_ff @(posedge clk) begin
    if (cmd.lv_start) begin
      lfound_r    <= 1'b0;
      lempty_ok_r <= 1'b0;
      bid_v_r <= 1'b0; bid_p_r <= '0; bid_s_r <= '0; bid_c_r <= '0;
      ask_v_r <= 1'b0; ask_p_r <= '0; ask_s_r <= '0; ask_c_r <= '0;
    end else if (l_rv_r) begin
      if (l_mode_r == LM_FIND) begin
        if (l_ru_r && lr_price == lt_price_r && !lfound_r) begin
          lfound_r <= 1'b1;
          lidx_r   <= l_ra_r;
          lprice_r <= lr_price;
          lsum_r   <= lr_sum;
          lcnt_r   <= lr_cnt;
        end
        if (!l_ru_r && !lempty_ok_r) begin
          lempty_ok_r <= 1'b1;
          lempty_r    <= l_ra_r;
        end
      end else if (l_ru_r) begin
        if ({1'b0, l_ra_r} < LV_HALF) begin
          if (!bid_v_r || lr_price > bid_p_r) begin
            bid_v_r <= 1'b1; bid_p_r <= lr_price; bid_s_r <= lr_sum; bid_c_r <= lr_cnt;
          end
        end else if (!ask_v_r || lr_price < ask_p_r) begin
          ask_v_r <= 1'b1; ask_p_r <= lr_price; ask_s_r <= lr_sum; ask_c_r <= lr_cnt;
        end
      end
    end
  end

  logic [SUM_W-1:0]          q64, rq64;
  logic                      rdrop;
  logic [SUM_W-1:0]          red_sum;
  logic [CNT_W-1:0]          red_cnt;
  logic                      lw_en;
  logic [LW-1:0]             lw_addr;
  logic signed [PRICE_W-1:0] lw_price;
  logic [SUM_W-1:0]          lw_sum;
  logic [CNT_W-1:0]          lw_cnt;

  assign q64     = {{(SUM_W-QTY_W){1'b0}}, qty_r};
  assign rq64    = (cmd.lv_op == LO_REDUCE_ALL) ? {{(SUM_W-QTY_W){1'b0}}, s_size_r}
                                                 : {{(SUM_W-QTY_W){1'b0}}, cut};
  assign rdrop   = (cmd.lv_op == LO_REDUCE_ALL) ? 1'b1 : left_zero;
  assign red_sum = (lsum_r >= rq64) ? lsum_r - rq64 : '0;
  assign red_cnt = (rdrop && lcnt_r != '0) ? lcnt_r - 1'b1 : lcnt_r;

  always_comb begin
    lw_en    = 1'b0;
    lw_addr  = lidx_r;
    lw_price = lprice_r;
    lw_sum   = red_sum;
    lw_cnt   = red_cnt;
    case (cmd.lv_op)
      LO_REDUCE_ALL, LO_REDUCE_CUT: lw_en = 1'b1;
      LO_GROW: begin
        lw_en = 1'b1;
        if (lfound_r) begin
          lw_sum = (lsum_r > SUM_MAX - q64) ? SUM_MAX : lsum_r + q64;
          lw_cnt = (lcnt_r < CNT_MAX) ? lcnt_r + 1'b1 : lcnt_r;
        end else begin
          lw_addr  = lempty_r;
          lw_price = price_r;
          lw_sum   = q64;
          lw_cnt   = CNT_W'(1);
        end
      end
      LO_PLACE: begin
        lw_en    = 1'b1;
        lw_addr  = side_r[0] ? LV_HALF[LW-1:0] : '0;
        lw_price = price_r;
        lw_sum   = q64;
        lw_cnt   = '0;
      end
      default: lw_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lw_en) begin
      lm_price[lw_addr] <= lw_price;
      lm_sum[lw_addr]   <= lw_sum;
      lm_cnt[lw_addr]   <= lw_cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lu_r <= '0;
    end else begin
      case (cmd.lv_op)
        LO_REDUCE_ALL, LO_REDUCE_CUT: lu_r[lidx_r] <= (red_cnt != '0);
        LO_GROW, LO_PLACE: lu_r[lw_addr] <= 1'b1;
        LO_CLR_SIDE: begin
          for (int i = 0; i < NLV; i++) begin
            if ((i >= LEVELS_PER_SIDE) == side_r[0]) lu_r[i] <= 1'b0;
          end
        end
        LO_CLR_ALL: lu_r <= '0;
        default: lu_r <= lu_r;
      endcase
    end
  end

  // result register
  logic out_valid_r;
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.load_out) out_valid_r <= 1'b1;
    else if (out_tready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      o_status      <= status_r;
      o_bid_valid   <= bid_v_r;
      o_bid_price   <= bid_p_r;
      o_bid_total   <= bid_s_r;
      o_bid_orders  <= bid_c_r;
      o_ask_valid   <= ask_v_r;
      o_ask_price   <= ask_p_r;
      o_ask_total   <= ask_s_r;
      o_ask_orders  <= ask_c_r;
      o_event_total <= evt_r;
    end
  end

  always_comb begin
    sts.slot_done  = slot_done;
    sts.lv_done    = lv_done;
    sts.inst_match = inst_ok_r;
    sts.cmd        = cmd_r;
    sts.side_ok    = !side_r[1];
    sts.tob        = tob_r;
    sts.qty_zero   = (qty_r == '0);
    sts.undef      = (price_r == UNDEF_PRICE);
    sts.sfound     = sfound_r;
    sts.sempty_ok  = sempty_ok_r;
    sts.lfound     = lfound_r;
    sts.lempty_ok  = lempty_ok_r;
    sts.out_free   = !out_valid_r || out_tready;
  end

endmodule

// ===== src/mbo_ctrl.sv =====
// Controller state machine sequencing table scans and updates per message.
module mbo_ctrl import mbo_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  typedef enum logic [10:0] {
    S_RST   = 11'b000_0000_0001,
    S_INIT  = 11'b000_0000_0010,
    S_IDLE  = 11'b000_0000_0100,
    S_DISP  = 11'b000_0000_1000,
    S_SFIND = 11'b000_0001_0000,
    S_TCLR  = 11'b000_0010_0000,
    S_OSCAN = 11'b000_0100_0000,
    S_NSCAN = 11'b000_1000_0000,
    S_SCLR  = 11'b001_0000_0000,
    S_BEST  = 11'b010_0000_0000,
    S_DONE  = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_RST;
    else state_r <= state_nxt;
  end

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    logic do_add, do_full, do_best;
    do_add    = 1'b0;
    do_full   = 1'b0;
    do_best   = 1'b0;
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_RST: begin
        cmd.slot_start = 1'b1;
        cmd.slot_mode  = SM_CLR_ALL;
        state_nxt      = S_INIT;
      end
      S_INIT: if (sts.slot_done) state_nxt = S_IDLE;
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_item = 1'b1;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        if (!sts.inst_match) begin
          do_best = 1'b1;
        end else begin
          case (sts.cmd)
            CMD_ADD: do_add = 1'b1;
            CMD_CANCEL, CMD_MODIFY: begin
              cmd.slot_start = 1'b1;
              cmd.slot_mode  = SM_FIND;
              state_nxt      = S_SFIND;
            end
            CMD_CLEAR: begin
              cmd.slot_start = 1'b1;
              cmd.slot_mode  = SM_CLR_ALL;
              cmd.lv_op      = LO_CLR_ALL;
              state_nxt      = S_SCLR;
            end
            default: do_best = 1'b1;
          endcase
        end
      end
      S_SFIND: begin
        if (sts.slot_done) begin
          if (sts.cmd == CMD_ADD) begin
            do_full = 1'b1;
          end else if (sts.sfound) begin
            cmd.lv_start = 1'b1;
            cmd.lv_mode  = LM_FIND;
            cmd.lv_old   = 1'b1;
            state_nxt    = S_OSCAN;
          end else if (sts.cmd == CMD_MODIFY) begin
            do_add = 1'b1;
          end else begin
            do_best = 1'b1;
          end
        end
      end
      S_TCLR: begin
        if (sts.slot_done) begin
          if (!sts.undef) cmd.lv_op = LO_PLACE;
          do_best = 1'b1;
        end
      end
      S_OSCAN: begin
        if (sts.lv_done) begin
          if (sts.cmd == CMD_CANCEL) begin
            if (sts.lfound) begin
              cmd.lv_op   = LO_REDUCE_CUT;
              cmd.slot_op = SO_CANCEL;
            end
            do_best = 1'b1;
          end else begin
            if (sts.lfound) cmd.lv_op = LO_REDUCE_ALL;
            if (sts.side_ok && !sts.qty_zero) begin
              cmd.lv_start = 1'b1;
              cmd.lv_mode  = LM_FIND;
              state_nxt    = S_NSCAN;
            end else begin
              cmd.slot_op = SO_FREE;
              do_best     = 1'b1;
            end
          end
        end
      end
      S_NSCAN: begin
        if (sts.lv_done) begin
          if (!sts.lfound && !sts.lempty_ok) begin
            cmd.set_full = 1'b1;
            if (sts.cmd == CMD_MODIFY) cmd.slot_op = SO_FREE;
          end else begin
            cmd.lv_op   = LO_GROW;
            cmd.slot_op = SO_PUT_NEW;
          end
          do_best = 1'b1;
        end
      end
      S_SCLR: if (sts.slot_done) do_best = 1'b1;
      S_BEST: if (sts.lv_done) state_nxt = S_DONE;
      S_DONE: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_RST;
    endcase

    if (do_add) begin
      if (!sts.side_ok) begin
        do_best = 1'b1;
      end else if (sts.tob) begin
        cmd.lv_op      = LO_CLR_SIDE;
        cmd.slot_start = 1'b1;
        cmd.slot_mode  = SM_CLR_SIDE;
        state_nxt      = S_TCLR;
      end else if (sts.qty_zero) begin
        do_best = 1'b1;
      end else if (sts.cmd == CMD_ADD) begin
        cmd.slot_start = 1'b1;
        cmd.slot_mode  = SM_FIND;
        state_nxt      = S_SFIND;
      end else begin
        do_full = 1'b1;
      end
    end
    if (do_full) begin
      if (!sts.sfound && !sts.sempty_ok) begin
        cmd.set_full = 1'b1;
        do_best      = 1'b1;
      end else begin
        cmd.lv_start = 1'b1;
        cmd.lv_mode  = LM_FIND;
        state_nxt    = S_NSCAN;
      end
    end
    if (do_best) begin
      cmd.lv_start = 1'b1;
      cmd.lv_mode  = LM_BEST;
      state_nxt    = S_BEST;
    end
  end

endmodule

// ===== src/mbo_limit_order_book_core.sv =====
// Top level of the market-by-order limit order book core.
//
//  channel | dir | handshake              | payload
//  in_     | in  | in_tvalid / in_tready   | in_tdata (fields), in_tuser (cmd, top_of_book)
//  out_    | out | out_tvalid / out_tready | out_tdata (best bid/ask, events), out_tuser
//  cfg_    | in  | cfg_valid / cfg_ready   | cfg_data (instrument_filter)
//
// One message at a time: in_tready is low from acceptance until the result is loaded.
// Add, cancel and modify scan the order table, then up to one price side, two for a
// modify of a known order; top-of-book adds and clears only pass the table. Every
// message ends with a best-price scan. After reset the order table is cleared before
// in_tready rises. A waiting result stalls only the final step of the next message.
module mbo_limit_order_book_core import mbo_pkg::*; #(
  parameter int ORDER_SLOTS     = ORDER_SLOTS_DEF,
  parameter int LEVELS_PER_SIDE = LEVELS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // instrument, book_side, price, quantity, order_key, zero pad
  input  logic [199:0] in_tdata,
  // cmd, top_of_book
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // bid_valid, bid_price, bid_total, bid_orders, ask_valid, ask_price,
  // ask_total, ask_orders, event_total, zero pad
  output logic [351:0] out_tdata,
  // status
  output logic [1:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [31:0]  cfg_data
);

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  logic                      o_bid_valid, o_ask_valid;
  logic signed [PRICE_W-1:0] o_bid_price, o_ask_price;
  logic [SUM_W-1:0]          o_bid_total, o_ask_total;
  logic [CNT_W-1:0]          o_bid_orders, o_ask_orders;
  logic [63:0]               o_event_total;

  assign cfg_ready = 1'b1;

  mbo_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  mbo_dp #(
    .ORDER_SLOTS     (ORDER_SLOTS),
    .LEVELS_PER_SIDE (LEVELS_PER_SIDE)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .i_cmd         (in_tuser[2:0]),
    .i_inst        (in_tdata[31:0]),
    .i_side        (in_tdata[33:32]),
    .i_price       (in_tdata[97:34]),
    .i_qty         (in_tdata[129:98]),
    .i_key         (in_tdata[193:130]),
    .i_tob         (in_tuser[3]),
    .cfg_we        (cfg_valid),
    .cfg_wdata     (cfg_data),
    .cmd           (cmd),
    .sts           (sts),
    .out_tready    (out_tready),
    .out_valid     (out_tvalid),
    .o_status      (out_tuser),
    .o_bid_valid   (o_bid_valid),
    .o_bid_price   (o_bid_price),
    .o_bid_total   (o_bid_total),
    .o_bid_orders  (o_bid_orders),
    .o_ask_valid   (o_ask_valid),
    .o_ask_price   (o_ask_price),
    .o_ask_total   (o_ask_total),
    .o_ask_orders  (o_ask_orders),
    .o_event_total (o_event_total)
  );

  assign out_tdata = {4'b0, o_event_total, o_ask_orders, o_ask_total, o_ask_price, o_ask_valid,
                      o_bid_orders, o_bid_total, o_bid_price, o_bid_valid};

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a message is in progress");

  a_bid_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o_bid_valid |-> o_bid_price == '0 && o_bid_total == '0 && o_bid_orders == '0)
    else $error("empty bid side reports non-zero level");

  a_ask_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o_ask_valid |-> o_ask_price == '0 && o_ask_total == '0 && o_ask_orders == '0)
    else $error("empty ask side reports non-zero level");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser == ST_APPLIED || out_tuser == ST_IGNORED || out_tuser == ST_FULL)
    else $error("undefined status code");

endmodule
